### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is high
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds around reset
`define CHK_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mi3_pkg.sv
// shared constants for the 3x3 matrix inverse
`default_nettype none
package mi3_pkg;

   localparam int NUM_ELEMS = 9;

   typedef logic [3:0] elem_idx_type;

   // cofactor i = m[a]*m[b] - m[c]*m[d], laid out as the adjugate (transposed)
   localparam elem_idx_type COF_IDX [NUM_ELEMS][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage
`default_nettype wire

### rtl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate, fully pipelined
// req channel: one word is a whole matrix, nine signed fixed-point elements,
//   row-major, a00 in the lowest bits of req_tdata.
// rsp channel: one word per matrix, the nine inverse elements in the same
//   layout; rsp_tuser[0] flags a zero determinant (elements then zero),
//   rsp_tuser[1] flags that at least one element saturated.
// throughput: one matrix per cycle; req_tready stays high as long as the
//   receiver keeps up.
// stages: six for the cofactors and determinant, then in the nine divider
//   lanes an entry stage, one stage per quotient bit and a saturation stage,
//   then one output register.
// stall: with rsp_tready low one more word lands in the skid entry, then
//   the whole pipeline holds and req_tready drops until the skid drains.
// reset: synchronous, clears all valid bits; nothing is in flight after.
`default_nettype none
module matrix_inverse_3x3 #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // a00, a01, a02, a10, a11, a12, a20, a21, a22, zero fill
   input  logic [((mi3_pkg::NUM_ELEMS*ELEM_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, zero fill
   output logic [((mi3_pkg::NUM_ELEMS*ELEM_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // singular, overflow
   output logic [1:0]                                   rsp_tuser
);
   import mi3_pkg::*;

   localparam int W      = ELEM_WIDTH;
   localparam int CW     = 2 * W + 1;
   localparam int DW     = 3 * W + 3;
   localparam int DATA_W = ((NUM_ELEMS * W + 7) / 8) * 8;
   localparam int DIV_L  = W + 2;
   localparam int PIPE_L = 6 + DIV_L;
   localparam int BODY_W = NUM_ELEMS * W;
   localparam int PACK_W = BODY_W + 2;

   logic signed [W-1:0] elem [NUM_ELEMS];
   logic [CW-1:0]       cmag [NUM_ELEMS];
   logic                cneg [NUM_ELEMS];
   logic [DW-1:0]       dmag;
   logic                dneg;
   logic                dzero;
   logic signed [W-1:0] val [NUM_ELEMS];
   logic                ovf [NUM_ELEMS];
   logic                vld_ff  [PIPE_L];
   logic                zero_ff [DIV_L];
   logic                en;
   logic [BODY_W-1:0]   body;
   logic                ovf_any;
   logic [PACK_W-1:0]   pack;
   logic [PACK_W-1:0]   pack_out;

   always_comb begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
         elem[i] = $signed(req_tdata[i*W +: W]);
      end
   end

   mi3_cof #(.W(W)) u_cof (
      .clock     (clock),
      .en        (en),
      .elem_in   (elem),
      .cmag_out  (cmag),
      .cneg_out  (cneg),
      .dmag_out  (dmag),
      .dneg_out  (dneg),
      .dzero_out (dzero)
   );

   for (genvar g = 0; g < NUM_ELEMS; g++) begin : g_lane
      mi3_div #(.W(W), .F(FRAC_BITS)) u_div (
         .clock   (clock),
         .en      (en),
         .cmag_in (cmag[g]),
         .cneg_in (cneg[g]),
         .dmag_in (dmag),
         .dneg_in (dneg),
         .val_out (val[g]),
         .ovf_out (ovf[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_L; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < PIPE_L; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= dzero;
         for (int s = 1; s < DIV_L; s++) begin
            zero_ff[s] <= zero_ff[s-1];
         end
      end
   end

   // a singular matrix forces zeros and drops the saturation flag
   always_comb begin
      ovf_any = 1'b0;
      for (int i = 0; i < NUM_ELEMS; i++) begin
         body[i*W +: W] = zero_ff[DIV_L-1] ? '0 : val[i];
         ovf_any        = ovf_any | ovf[i];
      end
      pack = {ovf_any & !zero_ff[DIV_L-1], zero_ff[DIV_L-1], body};
   end

   mi3_skid #(.DATA_W(PACK_W)) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[PIPE_L-1]),
      .in_data   (pack),
      .en        (en),
      .out_valid (rsp_tvalid),
      .out_data  (pack_out),
      .out_ready (rsp_tready)
   );

   assign req_tready = en;
   assign rsp_tdata  = DATA_W'(pack_out[BODY_W-1:0]);
   assign rsp_tuser  = pack_out[PACK_W-1:BODY_W];

endmodule
`default_nettype wire

### rtl/mi3_cof.sv
// cofactor and determinant pipeline, six register stages
`default_nettype none
module mi3_cof #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [W-1:0] elem_in [mi3_pkg::NUM_ELEMS],
   output logic [2*W:0]        cmag_out [mi3_pkg::NUM_ELEMS],
   output logic                cneg_out [mi3_pkg::NUM_ELEMS],
   output logic [3*W+2:0]      dmag_out,
   output logic                dneg_out,
   output logic                dzero_out
);
   import mi3_pkg::*;

   localparam int PW = 2 * W;
   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int LW = W + 2;

   logic signed [PW-1:0]   pa_ff [NUM_ELEMS];
   logic signed [PW-1:0]   pb_ff [NUM_ELEMS];
   logic signed [W-1:0]    m1_ff [3];
   logic signed [W-1:0]    m2_ff [3];
   logic signed [CW-1:0]   cof2_ff [NUM_ELEMS];
   logic signed [CW-1:0]   cof3_ff [NUM_ELEMS];
   logic signed [CW-1:0]   cof4_ff [NUM_ELEMS];
   logic signed [CW-1:0]   cof5_ff [NUM_ELEMS];
   logic signed [LW+W-1:0] plo_ff [3];
   logic signed [PW-1:0]   phi_ff [3];
   logic signed [DW-1:0]   term_ff [3];
   logic signed [DW-1:0]   det_ff;
   logic [CW-1:0]          cmag_ff [NUM_ELEMS];
   logic                   cneg_ff [NUM_ELEMS];
   logic [DW-1:0]          dmag_ff;
   logic                   dneg_ff;
   logic                   dzero_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_ELEMS; i++) begin
            pa_ff[i]   <= elem_in[COF_IDX[i][0]] * elem_in[COF_IDX[i][1]];
            pb_ff[i]   <= elem_in[COF_IDX[i][2]] * elem_in[COF_IDX[i][3]];
            cof2_ff[i] <= CW'(pa_ff[i]) - CW'(pb_ff[i]);
            cof3_ff[i] <= cof2_ff[i];
            cof4_ff[i] <= cof3_ff[i];
            cof5_ff[i] <= cof4_ff[i];
            cneg_ff[i] <= cof5_ff[i][CW-1];
            cmag_ff[i] <= cof5_ff[i][CW-1] ? -cof5_ff[i] : cof5_ff[i];
         end
         for (int k = 0; k < 3; k++) begin
            m1_ff[k] <= elem_in[k];
            m2_ff[k] <= m1_ff[k];
            // top row times its cofactor, split so each product stays near w by w
            plo_ff[k] <= m2_ff[k] * $signed({1'b0, cof2_ff[3*k][W:0]});
            phi_ff[k] <= m2_ff[k] * $signed(cof2_ff[3*k][CW-1:W+1]);
            term_ff[k] <= (DW'(phi_ff[k]) <<< (W + 1)) + DW'(plo_ff[k]);
         end
         det_ff   <= term_ff[0] + term_ff[1] + term_ff[2];
         dneg_ff  <= det_ff[DW-1];
         dmag_ff  <= det_ff[DW-1] ? -det_ff : det_ff;
         dzero_ff <= (det_ff == '0);
      end
   end

   assign cmag_out  = cmag_ff;
   assign cneg_out  = cneg_ff;
   assign dmag_out  = dmag_ff;
   assign dneg_out  = dneg_ff;
   assign dzero_out = dzero_ff;

endmodule
`default_nettype wire

### rtl/mi3_div.sv
// pipelined restoring divider lane with saturation, one quotient bit per stage
`default_nettype none
module mi3_div #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic [2*W:0]        cmag_in,
   input  logic                cneg_in,
   input  logic [3*W+2:0]      dmag_in,
   input  logic                dneg_in,
   output logic signed [W-1:0] val_out,
   output logic                ovf_out
);
   localparam int CW = 2 * W + 1;
   localparam int DW = 3 * W + 3;
   localparam int NW = CW + 2 * F;
   localparam int HW = NW - W;
   localparam int R  = ((DW > HW) ? DW : HW) + 1;

   logic [NW-1:0] num;
   logic [R-1:0]  rem_ff  [W+1];
   logic [R-1:0]  d_ff    [W+1];
   logic [W-1:0]  nlow_ff [W+1];
   logic [W-1:0]  q_ff    [W+1];
   logic          neg_ff  [W+1];
   logic          sat_ff  [W+1];
   logic [R-1:0]  t_in    [W+1];
   logic          ge_in   [W+1];
   logic [W-1:0]  q;
   logic          big;
   logic signed [W-1:0] val_in;
   logic signed [W-1:0] val_ff;
   logic          ovf_ff;

   assign num = {cmag_in, {(2*F){1'b0}}};

   always_comb begin
      t_in[0]  = '0;
      ge_in[0] = 1'b0;
      for (int k = 1; k <= W; k++) begin
         t_in[k]  = {rem_ff[k-1][R-2:0], nlow_ff[k-1][W-1]};
         ge_in[k] = (t_in[k] >= d_ff[k-1]);
      end
   end

   // high part at or above the divisor means the quotient needs more than w bits
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= R'(num[NW-1:W]);
         sat_ff[0]  <= (R'(num[NW-1:W]) >= R'(dmag_in));
         d_ff[0]    <= R'(dmag_in);
         nlow_ff[0] <= num[W-1:0];
         q_ff[0]    <= '0;
         neg_ff[0]  <= cneg_in ^ dneg_in;
         for (int k = 1; k <= W; k++) begin
            rem_ff[k]  <= ge_in[k] ? (t_in[k] - d_ff[k-1]) : t_in[k];
            q_ff[k]    <= {q_ff[k-1][W-2:0], ge_in[k]};
            nlow_ff[k] <= nlow_ff[k-1] << 1;
            d_ff[k]    <= d_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
         end
         val_ff <= val_in;
         ovf_ff <= big;
      end
   end

   always_comb begin
      q = q_ff[W];
      if (neg_ff[W]) begin
         big    = sat_ff[W] || (q[W-1] && (|q[W-2:0]));
         val_in = big ? $signed({1'b1, {(W-1){1'b0}}}) : -$signed(q);
      end else begin
         big    = sat_ff[W] || q[W-1];
         val_in = big ? $signed({1'b0, {(W-1){1'b1}}}) : $signed(q);
      end
   end

   assign val_out = val_ff;
   assign ovf_out = ovf_ff;

endmodule
`default_nettype wire

### rtl/mi3_skid.sv
// output register with one skid entry; holds the pipeline while both are full
`default_nettype none
module mi3_skid #(
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DATA_W-1:0] in_data,
   output logic              en,
   output logic              out_valid,
   output logic [DATA_W-1:0] out_data,
   input  logic              out_ready
);
   logic              out_v_ff;
   logic              sk_v_ff;
   logic [DATA_W-1:0] out_d_ff;
   logic [DATA_W-1:0] sk_d_ff;
   logic              take;

   assign en   = !sk_v_ff;
   assign take = out_ready || !out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (take) begin
         if (sk_v_ff) begin
            out_v_ff <= 1'b1;
            sk_v_ff  <= 1'b0;
         end else begin
            out_v_ff <= in_valid;
         end
      end else if (in_valid && en) begin
         sk_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_d_ff <= sk_v_ff ? sk_d_ff : in_data;
      end else if (en) begin
         sk_d_ff <= in_data;
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_d_ff;

endmodule
`default_nettype wire

### rtl/mi3_checker.sv
// port-level checks for the matrix inverse, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module mi3_checker #(
   parameter int ELEM_WIDTH = 32
) (
   input wire                                                clock,
   input wire                                                reset,
   input wire                                                req_tready,
   input wire                                                rsp_tvalid,
   input wire                                                rsp_tready,
   input wire [((mi3_pkg::NUM_ELEMS*ELEM_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input wire [1:0]                                          rsp_tuser
);

   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp word changed while stalled")
   `CHK_ASSERT(a_singular_zero, clock, reset, rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1] && rsp_tdata == '0, "singular word not cleared")
   `CHK_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid, "rsp valid right after reset")
   `CHK_ASSERT(a_ready_low_full, clock, reset, !req_tready |-> rsp_tvalid, "input held with no word waiting")

endmodule

bind matrix_inverse_3x3 mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

### tb/matrix_inverse_3x3_tb.sv
// testbench for the 3x3 fixed-point matrix inverse: directed and random matrices, checked per word
`default_nettype none
module matrix_inverse_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EW = 32;
   localparam int NE = mi3_pkg::NUM_ELEMS;
   localparam int DW = ((NE*EW+7)/8)*8;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = EW + 30;

   typedef logic [EW-1:0] matrix_type [NE];
   typedef logic [191:0] wide_type;
   typedef struct {
      logic [EW-1:0] inv [NE];
      logic          singular;
      logic          overflow;
   } inverse_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;
   logic [1:0]    rsp_tuser;

   inverse_type expected_inverses [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          rsp_hold = 0;
   bit          no_idle = 1'b0;

   matrix_inverse_3x3 u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // exact adjugate over wide integers, quotient truncated toward zero then saturated
   function automatic inverse_type predict_inverse(input matrix_type a);
      logic signed [191:0] m [NE];
      logic signed [191:0] cof [NE];
      logic signed [191:0] det;
      wide_type dmag, num, q, bound;
      logic neg;
      inverse_type r;
      for (int i = 0; i < NE; i++) m[i] = $signed(a[i]);
      for (int i = 0; i < NE; i++)
         cof[i] = m[mi3_pkg::COF_IDX[i][0]] * m[mi3_pkg::COF_IDX[i][1]]
                - m[mi3_pkg::COF_IDX[i][2]] * m[mi3_pkg::COF_IDX[i][3]];
      det = m[0]*cof[0] + m[1]*cof[3] + m[2]*cof[6];
      r.singular = (det == 0);
      r.overflow = 1'b0;
      if (r.singular) begin
         for (int i = 0; i < NE; i++) r.inv[i] = '0;
         return r;
      end
      dmag = (det < 0) ? wide_type'(-det) : wide_type'(det);
      bound = wide_type'(1) << (EW-1);
      for (int i = 0; i < NE; i++) begin
         neg = (cof[i] < 0) != (det < 0);
         num = ((cof[i] < 0) ? wide_type'(-cof[i]) : wide_type'(cof[i])) << 32;
         q = num / dmag;
         if (q == 0) neg = 1'b0;
         if (!neg && q >= bound) begin
            q = bound - 1;
            r.overflow = 1'b1;
         end else if (neg && q > bound) begin
            q = bound;
            r.overflow = 1'b1;
         end
         r.inv[i] = neg ? -q[EW-1:0] : q[EW-1:0];
      end
      return r;
   endfunction

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // sends one matrix word and queues its inverse once accepted
   task automatic send_matrix(input matrix_type a);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      for (int i = 0; i < NE; i++) req_tdata[i*EW +: EW] <= a[i];
      do @(posedge clock); while (!req_tready);
      expected_inverses.push_back(predict_inverse(a));
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_hold == 1) begin
         rsp_tready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         automatic int n = draw_wait();
         rsp_tready <= (n == 0);
         rsp_hold <= n;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_inverses.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            automatic inverse_type e = expected_inverses.pop_front();
            for (int i = 0; i < NE; i++)
               if (rsp_tdata[i*EW +: EW] !== e.inv[i])
                  report_mismatch($sformatf("inv%0d%0d got %h expected %h",
                     i/3, i%3, rsp_tdata[i*EW +: EW], e.inv[i]));
            if (rsp_tuser[0] !== e.singular)
               report_mismatch($sformatf("singular got %b expected %b",
                  rsp_tuser[0], e.singular));
            if (rsp_tuser[1] !== e.overflow)
               report_mismatch($sformatf("overflow got %b expected %b",
                  rsp_tuser[1], e.overflow));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("matrix_inverse_3x3 test failed");
         $finish;
      end
   end

   function automatic matrix_type diag(input logic [EW-1:0] d0, d1, d2);
      matrix_type a;
      foreach (a[i]) a[i] = '0;
      a[0] = d0;
      a[4] = d1;
      a[8] = d2;
      return a;
   endfunction

   function automatic matrix_type fill_all(input logic [EW-1:0] v);
      matrix_type a;
      foreach (a[i]) a[i] = v;
      return a;
   endfunction

   task automatic test_directed();
      matrix_type a;
      send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
      send_matrix(fill_all('0));
      send_matrix(fill_all(32'h7fff_ffff));
      send_matrix(fill_all(32'h8000_0000));
      send_matrix(fill_all(32'hffff_ffff));
      // tiny determinant, the diagonal saturates high
      send_matrix(diag(32'd1, 32'd1, 32'd1));
      // quotient of exactly 2^31: positive saturates, negative lands on the minimum
      send_matrix(diag(32'd2, 32'd2, 32'd2));
      send_matrix(diag(-32'sd2, 32'd2, 32'd2));
      send_matrix(diag(-32'sd1, 32'd1, 32'd1));
      send_matrix(diag(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
      send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      // huge determinant, the inverse diagonal truncates to a raw value of 2
      send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      // truncation toward zero on a negative inverse
      send_matrix(diag(-32'sd196608, 32'h0003_0000, 32'h0007_0000));
      a = diag(32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
      a[1] = 32'hffff_0000;
      a[5] = 32'h0000_8000;
      a[6] = 32'h0001_8000;
      send_matrix(a);
   endtask

   task automatic test_random_full(input int count);
      matrix_type a;
      repeat (count) begin
         foreach (a[i]) a[i] = $urandom();
         send_matrix(a);
      end
   endtask

   // well-scaled matrices around unity, with a few tiny ones that overflow
   task automatic test_random_scaled(input int count);
      matrix_type a;
      int span;
      repeat (count) begin
         span = ($urandom_range(0, 9) == 0) ? 64 : 32'h0004_0000;
         foreach (a[i]) a[i] = $urandom_range(0, 2*span) - span;
         if ($urandom_range(0, 1)) begin
            a[0] += 32'h0001_0000;
            a[4] += 32'h0001_0000;
            a[8] += 32'h0001_0000;
         end
         send_matrix(a);
      end
   endtask

   task automatic test_singular(input int count);
      matrix_type a;
      int r0, r1, k;
      repeat (count) begin
         foreach (a[i]) a[i] = ($urandom_range(0, 1)) ? $urandom()
                                                      : $urandom_range(0, 32'h0008_0000);
         r0 = $urandom_range(0, 2);
         r1 = (r0 + $urandom_range(1, 2)) % 3;
         k = $urandom_range(0, 6) - 3;
         case ($urandom_range(0, 2))
            0: for (int c = 0; c < 3; c++) a[r1*3+c] = a[r0*3+c] * k;
            1: for (int c = 0; c < 3; c++) a[c*3+r1] = a[c*3+r0] * k;
            default: for (int c = 0; c < 3; c++) a[r1*3+c] = '0;
         endcase
         send_matrix(a);
      end
   endtask

   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      test_random_scaled(count / 2);
      test_random_full(count - count / 2);
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_full(150);
      test_random_scaled(190);
      test_singular(60);
      test_back_to_back(80);
      test_random_scaled(20);
      req_tvalid <= 1'b0;
      while (expected_inverses.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("matrix_inverse_3x3 test passed");
      else
         $display("matrix_inverse_3x3 test failed");
      $finish;
   end

endmodule
`default_nettype wire
